// ===== rtl/core/tdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline queue package
// Shared widths, command and result codes, and the command word that travels
// from the front end to the execution engine.
// ----------------------------------------------------------------------------
package tdq_pkg;

    localparam int CAPACITY_DEF    = 32;
    localparam int CMD_QUEUE_DEPTH = 2;

    localparam int OPCODE_W = 2;
    localparam int TIME_W   = 32;
    localparam int ID_W     = 32;
    localparam int KIND_W   = 3;
    localparam int COUNT_W  = 6;

    // Opcode values as they arrive on the command channel.
    localparam logic [OPCODE_W-1:0] OPC_ADD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OPC_CANCEL = 2'd1;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_CANCEL,
        CMD_UPDATE
    } cmd_op_t;

    typedef enum logic [KIND_W-1:0] {
        RES_ADDED     = 3'd0,
        RES_REJECTED  = 3'd1,
        RES_CANCELLED = 3'd2,
        RES_NOT_FOUND = 3'd3,
        RES_EXPIRED   = 3'd4,
        RES_DONE      = 3'd5
    } res_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_CANCEL_SCAN,
        S_MIN_SCAN,
        S_CHECK,
        S_EMIT
    } eng_state_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [TIME_W-1:0] time_value;
        logic [ID_W-1:0]   task_id;
    } cmd_t;

    // Ordering key: earlier deadline first, then smaller id.
    function automatic logic key_less(input logic [TIME_W-1:0] a_dl,
                                      input logic [ID_W-1:0]   a_id,
                                      input logic [TIME_W-1:0] b_dl,
                                      input logic [ID_W-1:0]   b_id);
        return {a_dl, a_id} < {b_dl, b_id};
    endfunction

endpackage

// ===== rtl/core/tdq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline queue front end
// Registers each incoming word, decodes its opcode and hands it to the
// command queue.
// ----------------------------------------------------------------------------
module tdq_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [tdq_pkg::OPCODE_W-1:0]  opcode,
    input  logic [tdq_pkg::TIME_W-1:0]    time_value,
    input  logic [tdq_pkg::ID_W-1:0]      task_id,
    output logic                          push_valid,
    input  logic                          push_ready,
    output tdq_pkg::cmd_t                 push_cmd
);
    import tdq_pkg::*;

    logic    stage_valid_reg;
    cmd_t    stage_cmd_reg;
    cmd_t    decoded;
    cmd_op_t op_dec;
    logic    take;

    // Opcodes two and three are both treated as an update.
    always_comb
    begin
        unique case (opcode)
            OPC_ADD:    op_dec = CMD_ADD;
            OPC_CANCEL: op_dec = CMD_CANCEL;
            default:    op_dec = CMD_UPDATE;
        endcase
        decoded.op         = op_dec;
        decoded.time_value = time_value;
        decoded.task_id    = task_id;
    end

    assign cmd_ready  = !stage_valid_reg || push_ready;
    assign take       = cmd_valid && cmd_ready;
    assign push_valid = stage_valid_reg;
    assign push_cmd   = stage_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_cmd_reg <= decoded;
        end
    end

endmodule

// ===== rtl/core/tdq_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline queue command FIFO
// A short queue that decouples the front end from the execution engine.
// ----------------------------------------------------------------------------
module tdq_cmd_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  tdq_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output tdq_pkg::cmd_t pop_cmd
);
    import tdq_pkg::*;

    localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
    localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

    cmd_t             entry_reg [CMD_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(CMD_QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(CMD_QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(CMD_QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/tdq_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline queue execution engine
// Owns the slot table, runs add, cancel and update, and keeps the cached
// earliest entry, which is rebuilt by a sweep of the slot memory.
// ----------------------------------------------------------------------------
module tdq_engine
#(
    parameter int CAPACITY = tdq_pkg::CAPACITY_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  tdq_pkg::cmd_t                 pop_cmd,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [tdq_pkg::KIND_W-1:0]    result_kind,
    output logic [tdq_pkg::ID_W-1:0]      result_id,
    output logic [tdq_pkg::TIME_W-1:0]    next_deadline,
    output logic                          queue_empty,
    output logic [tdq_pkg::COUNT_W-1:0]   pending_count,
    output logic                          last
);
    import tdq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int OCC_W = $clog2(CAPACITY + 1);

    eng_state_t state_reg;
    eng_state_t state_next;

    // Current command.
    logic [TIME_W-1:0] tv_reg;
    logic [ID_W-1:0]   tid_reg;

    // Slot table: valid bits in flops, deadline and id in a memory.
    logic [CAPACITY-1:0]      valid_reg;
    logic [TIME_W+ID_W-1:0]   slot_mem_reg [CAPACITY];
    logic [TIME_W+ID_W-1:0]   rd_data_reg;
    logic [ID_W-1:0]          next_id_reg;
    logic [OCC_W-1:0]         occ_reg;

    // Sweep control.
    logic [IDX_W-1:0] scan_addr_reg;
    logic             issue_done_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             best_found_reg;

    // Cached earliest entry.
    logic [TIME_W-1:0] min_dl_reg;
    logic [ID_W-1:0]   min_id_reg;
    logic [IDX_W-1:0]  min_idx_reg;

    // Result waiting to be presented.
    res_kind_t       pend_kind_reg;
    logic [ID_W-1:0] pend_id_reg;

    // Output register.
    logic                res_valid_reg;
    res_kind_t           res_kind_reg;
    logic [ID_W-1:0]     res_id_reg;
    logic [TIME_W-1:0]   res_dl_reg;
    logic                res_empty_reg;
    logic [COUNT_W-1:0]  res_count_reg;
    logic                res_last_reg;

    logic [TIME_W-1:0] rd_dl;
    logic [ID_W-1:0]   rd_id;
    logic [IDX_W-1:0]  free_idx;
    logic              full;
    logic              scan_end;
    logic              match;
    logic              hit_any;
    logic [IDX_W-1:0]  hit_idx_sel;
    logic              expire_now;
    logic              scan_take;
    logic              add_is_min;
    logic              out_free;
    logic              in_scan;
    logic              scan_init;
    logic              mem_re;
    logic              mem_we;
    logic              out_load;

    assign rd_dl = rd_data_reg[TIME_W+ID_W-1:ID_W];
    assign rd_id = rd_data_reg[ID_W-1:0];

    // Lowest free slot.
    always_comb
    begin
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign full        = occ_reg == OCC_W'(CAPACITY);
    assign scan_end    = rd_vld_reg && (rd_idx_reg == IDX_W'(CAPACITY - 1));
    assign match       = rd_vld_reg && valid_reg[rd_idx_reg] && (rd_id == tid_reg);
    assign hit_any     = hit_reg || match;
    assign hit_idx_sel = hit_reg ? hit_idx_reg : rd_idx_reg;
    assign expire_now  = (occ_reg != '0) && (min_dl_reg <= tv_reg);
    assign scan_take   = rd_vld_reg && valid_reg[rd_idx_reg] &&
                         (!best_found_reg || key_less(rd_dl, rd_id, min_dl_reg, min_id_reg));
    assign add_is_min  = (occ_reg == '0) ||
                         key_less(tv_reg, next_id_reg, min_dl_reg, min_id_reg) ||
                         (tv_reg == min_dl_reg && next_id_reg == min_id_reg &&
                          free_idx < min_idx_reg);
    assign out_free    = !res_valid_reg || res_ready;
    assign in_scan     = (state_reg == S_CANCEL_SCAN) || (state_reg == S_MIN_SCAN);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    unique case (pop_cmd.op)
                        CMD_ADD:    state_next = S_ADD;
                        CMD_CANCEL: state_next = S_CANCEL_SCAN;
                        default:    state_next = S_CHECK;
                    endcase
                end
            end
            S_ADD:
            begin
                state_next = S_EMIT;
            end
            S_CANCEL_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = hit_any ? S_MIN_SCAN : S_EMIT;
                end
            end
            S_MIN_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_EMIT;
                end
            end
            S_CHECK:
            begin
                state_next = expire_now ? S_MIN_SCAN : S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (pend_kind_reg == RES_EXPIRED) ? S_CHECK : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        pop_ready = (state_reg == S_IDLE);
        mem_we    = (state_reg == S_ADD) && !full;
        mem_re    = in_scan && !issue_done_reg;
        out_load  = (state_reg == S_EMIT) && out_free;
        scan_init = ((state_next == S_CANCEL_SCAN) || (state_next == S_MIN_SCAN)) &&
                    (state_next != state_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem_reg[free_idx] <= {tv_reg, next_id_reg};
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem_reg[scan_addr_reg];
        end
    end

    // Control state of the table and the sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            next_id_reg    <= '0;
            occ_reg        <= '0;
            scan_addr_reg  <= '0;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            best_found_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= mem_re;
            if (scan_init)
            begin
                scan_addr_reg  <= '0;
                issue_done_reg <= 1'b0;
                hit_reg        <= 1'b0;
                best_found_reg <= 1'b0;
            end
            else if (mem_re)
            begin
                if (scan_addr_reg == IDX_W'(CAPACITY - 1))
                begin
                    issue_done_reg <= 1'b1;
                end
                else
                begin
                    scan_addr_reg <= scan_addr_reg + IDX_W'(1);
                end
            end

            unique case (state_reg)
                S_ADD:
                begin
                    if (!full)
                    begin
                        valid_reg[free_idx] <= 1'b1;
                        next_id_reg         <= next_id_reg + ID_W'(1);
                        occ_reg             <= occ_reg + OCC_W'(1);
                    end
                end
                S_CANCEL_SCAN:
                begin
                    if (match && !hit_reg && !scan_init)
                    begin
                        hit_reg <= 1'b1;
                    end
                    if (scan_end && hit_any)
                    begin
                        valid_reg[hit_idx_sel] <= 1'b0;
                        occ_reg                <= occ_reg - OCC_W'(1);
                    end
                end
                S_MIN_SCAN:
                begin
                    if (scan_take)
                    begin
                        best_found_reg <= 1'b1;
                    end
                end
                S_CHECK:
                begin
                    if (expire_now)
                    begin
                        valid_reg[min_idx_reg] <= 1'b0;
                        occ_reg                <= occ_reg - OCC_W'(1);
                    end
                end
                default:
                begin
                end
            endcase

            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            tv_reg  <= pop_cmd.time_value;
            tid_reg <= pop_cmd.task_id;
        end

        unique case (state_reg)
            S_ADD:
            begin
                if (full)
                begin
                    pend_kind_reg <= RES_REJECTED;
                    pend_id_reg   <= '0;
                end
                else
                begin
                    pend_kind_reg <= RES_ADDED;
                    pend_id_reg   <= next_id_reg;
                    if (add_is_min)
                    begin
                        min_dl_reg  <= tv_reg;
                        min_id_reg  <= next_id_reg;
                        min_idx_reg <= free_idx;
                    end
                end
            end
            S_CANCEL_SCAN:
            begin
                if (match && !hit_reg)
                begin
                    hit_idx_reg <= rd_idx_reg;
                end
                if (scan_end)
                begin
                    pend_kind_reg <= hit_any ? RES_CANCELLED : RES_NOT_FOUND;
                    pend_id_reg   <= hit_any ? tid_reg : '0;
                end
            end
            S_MIN_SCAN:
            begin
                if (scan_take)
                begin
                    min_dl_reg  <= rd_dl;
                    min_id_reg  <= rd_id;
                    min_idx_reg <= rd_idx_reg;
                end
            end
            S_CHECK:
            begin
                pend_kind_reg <= expire_now ? RES_EXPIRED : RES_DONE;
                pend_id_reg   <= expire_now ? min_id_reg : '0;
            end
            default:
            begin
            end
        endcase

        if (mem_re)
        begin
            rd_idx_reg <= scan_addr_reg;
        end

        if (out_load)
        begin
            res_kind_reg  <= pend_kind_reg;
            res_id_reg    <= pend_id_reg;
            res_dl_reg    <= (occ_reg == '0) ? '0 : min_dl_reg;
            res_empty_reg <= (occ_reg == '0);
            res_count_reg <= COUNT_W'(occ_reg);
            res_last_reg  <= (pend_kind_reg != RES_EXPIRED);
        end
    end

    assign res_valid     = res_valid_reg;
    assign result_kind   = res_kind_reg;
    assign result_id     = res_id_reg;
    assign next_deadline = res_dl_reg;
    assign queue_empty   = res_empty_reg;
    assign pending_count = res_count_reg;
    assign last          = res_last_reg;

endmodule

// ===== rtl/core/timer_deadline_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline queue
// Table of pending timeouts with add, cancel and expire-by-time operations.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the cmd channel (cmd_valid / cmd_ready) as one word with
// opcode, time_value and task_id. Results leave on the res channel
// (res_valid / res_ready), one word each; last marks the final word of a
// command. Add and cancel give one word; update gives one expired word per
// due timeout, earliest deadline first, and then a closing word.
// Buffering and pacing: the front end registers the word and a two-entry
// command queue holds it, so up to three commands can be taken while the
// engine is busy. The engine runs one command at a time. Add needs no sweep.
// Cancel sweeps the slot memory once to find the id and, on a hit, once
// more to rebuild the earliest entry. Update sweeps once per expired timeout
// to rebuild the earliest entry. The sweeps are paced by the single read port
// of the slot memory, one slot per cycle.
// Reset clears all valid bits, the id counter and the count at once; there
// is no clearing pass. When the receiver stalls, the result register holds
// its word and the engine waits in its emit step; the queue keeps filling.
// ----------------------------------------------------------------------------
module timer_deadline_queue
#(
    parameter int CAPACITY = tdq_pkg::CAPACITY_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [tdq_pkg::OPCODE_W-1:0]  opcode,
    input  logic [tdq_pkg::TIME_W-1:0]    time_value,
    input  logic [tdq_pkg::ID_W-1:0]      task_id,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [tdq_pkg::KIND_W-1:0]    result_kind,
    output logic [tdq_pkg::ID_W-1:0]      result_id,
    output logic [tdq_pkg::TIME_W-1:0]    next_deadline,
    output logic                          queue_empty,
    output logic [tdq_pkg::COUNT_W-1:0]   pending_count,
    output logic                          last
);
    import tdq_pkg::*;

    // Front end to queue.
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;

    // Queue to engine.
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    tdq_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .opcode     (opcode),
        .time_value (time_value),
        .task_id    (task_id),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    tdq_cmd_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // The engine owns the slot table and the result register.
    tdq_engine
    #(
        .CAPACITY (CAPACITY)
    )
    u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_cmd       (pop_cmd),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .result_kind   (result_kind),
        .result_id     (result_id),
        .next_deadline (next_deadline),
        .queue_empty   (queue_empty),
        .pending_count (pending_count),
        .last          (last)
    );

endmodule

// ===== rtl/core/tdq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline queue checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tdq_checker
#(
    parameter int CAPACITY = tdq_pkg::CAPACITY_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [tdq_pkg::KIND_W-1:0]    result_kind,
    input logic [tdq_pkg::ID_W-1:0]      result_id,
    input logic [tdq_pkg::TIME_W-1:0]    next_deadline,
    input logic                          queue_empty,
    input logic [tdq_pkg::COUNT_W-1:0]   pending_count,
    input logic                          last
);
    import tdq_pkg::*;

    // A stalled result word holds.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(result_kind) &&
        $stable(result_id) && $stable(next_deadline) && $stable(last))
        else $error("result word changed while stalled");

    // The empty flag, the count and the reported deadline agree.
    a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (queue_empty == (pending_count == '0)) &&
        (!queue_empty || next_deadline == '0))
        else $error("empty flag disagrees with count or deadline");

    // A rejected add only happens on a full table.
    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind == RES_REJECTED |->
        result_id == '0 && pending_count == COUNT_W'(CAPACITY))
        else $error("add rejected while table not full");

    // Expiry words are never last; every other kind closes its command.
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (last == (result_kind != RES_EXPIRED)))
        else $error("last flag wrong for result kind");

endmodule

bind timer_deadline_queue tdq_checker
#(
    .CAPACITY (CAPACITY)
)
u_tdq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .result_kind   (result_kind),
    .result_id     (result_id),
    .next_deadline (next_deadline),
    .queue_empty   (queue_empty),
    .pending_count (pending_count),
    .last          (last)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline queue testbench
// Drives add, cancel and update words into the queue under bursty traffic
// and a stalling receiver. A cycle-free software copy of the timeout table
// predicts every result word, and the monitor checks each one field by field
// in order of arrival.
// ----------------------------------------------------------------------------
module testbench;

    import tdq_pkg::*;

    localparam int CAP = tdq_pkg::CAPACITY_DEF;

    // The package only names add and cancel; every other opcode is an update.
    localparam logic [OPCODE_W-1:0] OPC_UPDATE     = 2'd2;
    localparam logic [OPCODE_W-1:0] OPC_UPDATE_ALT = 2'd3;

    localparam logic [TIME_W-1:0] TIME_MAX = 32'hFFFF_FFFF;
    localparam logic [ID_W-1:0]   ID_MAX   = 32'hFFFF_FFFF;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [TIME_W-1:0]   tv;
        logic [ID_W-1:0]     tid;
    } timer_word_t;

    typedef struct {
        res_kind_t           kind;
        logic [ID_W-1:0]     rid;
        logic [TIME_W-1:0]   next_dl;
        logic                empty;
        logic [COUNT_W-1:0]  count;
        logic                is_last;
    } timeout_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_ready;
    logic [OPCODE_W-1:0] opcode = '0;
    logic [TIME_W-1:0]   time_value = '0;
    logic [ID_W-1:0]     task_id = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    logic [KIND_W-1:0]   result_kind;
    logic [ID_W-1:0]     result_id;
    logic [TIME_W-1:0]   next_deadline;
    logic                queue_empty;
    logic [COUNT_W-1:0]  pending_count;
    logic                last;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    timer_deadline_queue #(.CAPACITY(CAP)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .opcode        (opcode),
        .time_value    (time_value),
        .task_id       (task_id),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .result_kind   (result_kind),
        .result_id     (result_id),
        .next_deadline (next_deadline),
        .queue_empty   (queue_empty),
        .pending_count (pending_count),
        .last          (last)
    );

    // ------------------------------------------------------------------
    // Shadow timeout table. It is updated in the order words are accepted,
    // which is the order the engine executes them, so the results it adds
    // line up with the result words the block sends.
    // ------------------------------------------------------------------
    logic                slot_used [CAP];
    logic [TIME_W-1:0]   slot_dl   [CAP];
    logic [ID_W-1:0]     slot_tid  [CAP];
    logic [ID_W-1:0]     id_counter = '0;
    logic [COUNT_W-1:0]  used_count = '0;

    timer_word_t         pending_words [$];
    timeout_result_t     due_results [$];
    int                  error_count = 0;
    int                  results_seen = 0;

    // Earliest pending slot: smallest deadline, then smallest id, then the
    // lowest index (the strict compare keeps the first one found).
    function automatic int earliest_slot();
        int best;
        int i;
        best = -1;
        for (i = 0; i < CAP; i++)
        begin
            if (slot_used[i])
            begin
                if (best < 0 || slot_dl[i] < slot_dl[best] ||
                    (slot_dl[i] == slot_dl[best] && slot_tid[i] < slot_tid[best]))
                    best = i;
            end
        end
        return best;
    endfunction

    // Each result reports the table as it stands after the result's effect.
    task automatic push_result(input res_kind_t kind, input logic [ID_W-1:0] rid,
                               input logic is_last);
        timeout_result_t r;
        int best;
        best = earliest_slot();
        r.kind    = kind;
        r.rid     = rid;
        r.next_dl = (best >= 0) ? slot_dl[best] : '0;
        r.empty   = (used_count == 0);
        r.count   = used_count;
        r.is_last = is_last;
        due_results.insert(due_results.size(), r);
    endtask

    task automatic apply_timer_command(input timer_word_t w);
        int  slot;
        int  i;
        int  best;
        bit  draining;
        slot = -1;
        if (w.op == OPC_ADD)
        begin
            for (i = 0; i < CAP && slot < 0; i++)
                if (!slot_used[i])
                    slot = i;
            if (slot < 0)
                push_result(RES_REJECTED, '0, 1'b1);
            else
            begin
                slot_used[slot] = 1'b1;
                slot_dl[slot]   = w.tv;
                slot_tid[slot]  = id_counter;
                used_count      = used_count + 1'b1;
                push_result(RES_ADDED, id_counter, 1'b1);
                id_counter      = id_counter + 1'b1;
            end
        end
        else if (w.op == OPC_CANCEL)
        begin
            for (i = 0; i < CAP && slot < 0; i++)
                if (slot_used[i] && slot_tid[i] == w.tid)
                    slot = i;
            if (slot < 0)
                push_result(RES_NOT_FOUND, '0, 1'b1);
            else
            begin
                slot_used[slot] = 1'b0;
                used_count      = used_count - 1'b1;
                push_result(RES_CANCELLED, w.tid, 1'b1);
            end
        end
        else
        begin
            // Update, opcode three included: expire everything not after tv.
            draining = 1'b1;
            while (draining)
            begin
                best = earliest_slot();
                if (best < 0 || slot_dl[best] > w.tv)
                    draining = 1'b0;
                else
                begin
                    slot_used[best] = 1'b0;
                    used_count      = used_count - 1'b1;
                    push_result(RES_EXPIRED, slot_tid[best], 1'b0);
                end
            end
            push_result(RES_DONE, '0, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued words in bursts of random length separated by
    // random gaps. A word stays on the pins until it is taken.
    // ------------------------------------------------------------------
    timer_word_t  cur_word = '{op: '0, tv: '0, tid: '0};
    logic         offer_next;
    int           burst_left = 1;
    int           gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else
        begin
            offer_next = cmd_valid;
            if (cmd_valid && cmd_ready)
            begin
                apply_timer_command(cur_word);
                offer_next = 1'b0;
            end
            if (!offer_next)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_words.size() > 0)
                begin
                    cur_word   = pending_words.pop_front();
                    offer_next = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        // Mostly short bursts, now and then a long unbroken run.
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(1, 8);
                        gap_left   = $urandom_range(0, 6);
                    end
                end
            end
            cmd_valid  <= offer_next;
            opcode     <= cur_word.op;
            time_value <= cur_word.tv;
            task_id    <= cur_word.tid;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: the ready pattern is drawn at random from four modes. Twice
    // in the run it holds off for a long stretch so the command queue fills
    // and the block stops taking words while the driver keeps offering.
    // ------------------------------------------------------------------
    logic         ready_next;
    int unsigned  rx_cycle = 0;
    int           rx_mode = 0;
    int           hold_left = 0;
    bit           first_hold_done = 1'b0;
    bit           second_hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            rx_cycle++;
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (!first_hold_done && results_seen >= 30)
            begin
                first_hold_done = 1'b1;
                hold_left       = 500;
                ready_next      = 1'b0;
            end
            else if (!second_hold_done && results_seen >= 150)
            begin
                second_hold_done = 1'b1;
                hold_left        = 400;
                ready_next       = 1'b0;
            end
            else
            begin
                if (rx_cycle % 32 == 0)
                    rx_mode = $urandom_range(0, 3);
                case (rx_mode)
                    0:       ready_next = 1'b1;
                    1:       ready_next = ($urandom_range(0, 1) == 1);
                    2:       ready_next = (rx_cycle % 4 != 3);
                    default: ready_next = ($urandom_range(0, 3) == 0);
                endcase
            end
            res_ready <= ready_next;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result word is matched against the oldest
    // prediction.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            results_seen <= results_seen + 1;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual kind %0d id %0h",
                         $time, result_kind, result_id);
                error_count++;
            end
            else
            begin
                timeout_result_t want;
                want = due_results.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(result_kind));
                check_field("result_id", want.rid, result_id);
                check_field("next_deadline", want.next_dl, next_deadline);
                check_field("queue_empty", 32'(want.empty), 32'(queue_empty));
                check_field("pending_count", 32'(want.count), 32'(pending_count));
                check_field("last", 32'(want.is_last), 32'(last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic [ID_W-1:0]   ids_handed;   // ids the generator believes were given
    logic [TIME_W-1:0] gen_now;      // a slowly advancing notion of time
    int                word_total;

    task automatic queue_word(input logic [OPCODE_W-1:0] op, input logic [TIME_W-1:0] tv,
                              input logic [ID_W-1:0] tid);
        timer_word_t w;
        w.op  = op;
        w.tv  = tv;
        w.tid = tid;
        pending_words.insert(pending_words.size(), w);
        word_total++;
    endtask

    function automatic logic [OPCODE_W-1:0] pick_update_op();
        return ($urandom_range(0, 4) == 0) ? OPC_UPDATE_ALT : OPC_UPDATE;
    endfunction

    // A recently handed-out id, so most cancels hit a live timeout.
    function automatic logic [ID_W-1:0] recent_id(input int span);
        int unsigned back;
        back = $urandom_range(1, span);
        return (ids_handed >= back) ? ids_handed - back : '0;
    endfunction

    task automatic build_fill_sequence();
        int n;
        int i;
        // Drain first so the table is known to be empty, then overfill it.
        queue_word(pick_update_op(), TIME_MAX, $urandom);
        n = CAP + $urandom_range(1, 3);
        for (i = 0; i < n; i++)
            queue_word(OPC_ADD, gen_now + $urandom_range(0, 15), $urandom);
        ids_handed = ids_handed + CAP;
        for (i = 0; i < 3; i++)
            queue_word(OPC_CANCEL, $urandom, recent_id(CAP));
        for (i = 0; i < 2; i++)
            queue_word(OPC_ADD, gen_now + $urandom_range(0, 15), $urandom);
        ids_handed = ids_handed + 2;
        // Partial expiry with many equal deadlines, then clear the rest.
        queue_word(pick_update_op(), gen_now + 7, $urandom);
        queue_word(pick_update_op(), gen_now + 15, $urandom);
        gen_now = gen_now + 20;
    endtask

    task automatic build_mixed_sequence();
        int n;
        int i;
        int pick;
        n = $urandom_range(10, 20);
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_word(OPC_ADD, $urandom, $urandom);
                else
                    queue_word(OPC_ADD, gen_now + $urandom_range(0, 200), $urandom);
                ids_handed = ids_handed + 1;
            end
            else if (pick < 65)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    queue_word(OPC_CANCEL, $urandom, $urandom);
                    2:       queue_word(OPC_CANCEL, $urandom, ids_handed);
                    default: queue_word(OPC_CANCEL, $urandom, recent_id(40));
                endcase
            end
            else
            begin
                gen_now = gen_now + $urandom_range(0, 100);
                if ($urandom_range(0, 9) == 0)
                    queue_word(pick_update_op(), $urandom, $urandom);
                else
                    queue_word(pick_update_op(), gen_now, $urandom);
            end
        end
    endtask

    initial
    begin
        int i;
        for (i = 0; i < CAP; i++)
        begin
            slot_used[i] = 1'b0;
            slot_dl[i]   = '0;
            slot_tid[i]  = '0;
        end
        word_total = 0;

        // Directed part: field extremes, equal deadlines, misses, opcode
        // three, and update and cancel on an empty table.
        queue_word(OPC_ADD, TIME_MAX, ID_MAX);        // id 0 at the latest time
        queue_word(OPC_ADD, '0, '0);                  // id 1 at time zero
        queue_word(OPC_ADD, 32'd100, 32'h5555_5555);  // ids 2..4 share a deadline
        queue_word(OPC_ADD, 32'd100, 32'hAAAA_AAAA);
        queue_word(OPC_ADD, 32'd100, '0);
        queue_word(OPC_CANCEL, TIME_MAX, ID_MAX);     // unknown id
        queue_word(OPC_CANCEL, '0, 32'd3);            // hit in the middle of a tie
        queue_word(OPC_CANCEL, '0, 32'd3);            // same id again misses
        queue_word(OPC_UPDATE, '0, ID_MAX);           // expires only the zero deadline
        queue_word(OPC_UPDATE, 32'd99, '0);           // nothing due
        queue_word(OPC_UPDATE, 32'd100, ID_MAX);      // tie resolved by id
        queue_word(OPC_UPDATE_ALT, TIME_MAX - 1, '0); // opcode three, one short
        queue_word(OPC_UPDATE_ALT, TIME_MAX, '0);     // expires the latest deadline
        queue_word(OPC_UPDATE, TIME_MAX, ID_MAX);     // update on an empty table
        queue_word(OPC_CANCEL, '0, '0);               // cancel on an empty table
        queue_word(OPC_ADD, 32'h8000_0000, ID_MAX);   // id 5
        queue_word(OPC_CANCEL, TIME_MAX, 32'd5);
        ids_handed = 32'd6;
        gen_now    = 32'd1000;

        // Random part: mostly mixed traffic on a moving clock, with a few
        // sequences that overfill the table.
        while (word_total < 210)
        begin
            if ($urandom_range(0, 6) == 0)
                build_fill_sequence();
            else
                build_mixed_sequence();
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || cmd_valid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        // Let a late stray word show up before the verdict.
        repeat (200) @(posedge clk);

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
        $display("testbench: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/tdq_pkg.sv
rtl/core/tdq_front.sv
rtl/core/tdq_cmd_fifo.sv
rtl/core/tdq_engine.sv
rtl/core/timer_deadline_queue.sv
rtl/core/tdq_checker.sv
bench/testbench.sv
